>>> hw/rtl/brf_pkg.sv
// Shared types, widths and helper functions for the byte ring FIFO.
// Used by the channel interfaces, the controller, the datapath and the top level.
package brf_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int OP_W      = 3;
  localparam int BYTE_W    = 8;
  localparam int VALUE_W   = 32;
  localparam int TAKEN_W   = 3;
  localparam int FILL_W    = 9;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_PULL8  = 3'd1,
    OP_PULL16 = 3'd2,
    OP_PULL32 = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec_single;
    logic issue;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_pull;
    logic can_issue;
  } sts_t;

  // Number of bytes a pull word asks for; zero for any other word.
  function automatic logic [TAKEN_W-1:0] want_bytes(logic [OP_W-1:0] op);
    logic [TAKEN_W-1:0] n;
    case (op)
      OP_PULL8:  n = 3'd1;
      OP_PULL16: n = 3'd2;
      OP_PULL32: n = 3'd4;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

>>> hw/rtl/brf_in_if.sv
// Input channel interface: valid/ready handshake with op code and data byte.
// Depends on brf_pkg for the field widths.
interface brf_in_if;
  logic                          valid;
  logic                          ready;
  logic [brf_pkg::OP_W-1:0]      op;
  logic [brf_pkg::BYTE_W-1:0]    data_in;

  modport source (output valid, output op, output data_in, input ready);
  modport sink (input valid, input op, input data_in, output ready);
endinterface

>>> hw/rtl/brf_out_if.sv
// Result channel interface: valid/ready handshake with the result fields.
// Depends on brf_pkg for the field widths.
interface brf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [brf_pkg::VALUE_W-1:0]   value;
  logic [brf_pkg::TAKEN_W-1:0]   bytes_taken;
  logic [brf_pkg::FILL_W-1:0]    fill_count;

  modport source (output valid, output status, output value, output bytes_taken,
                  output fill_count, input ready);
  modport sink (input valid, input status, input value, input bytes_taken,
                input fill_count, output ready);
endinterface

>>> hw/rtl/brf_ctrl.sv
// Controller state machine of the byte ring FIFO.
// Sequences each word through execute and result load; depends on brf_pkg.
module brf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  brf_pkg::sts_t sts,
  output brf_pkg::cmd_t cmd
);

  brf_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == brf_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brf_pkg::S_IDLE: begin
        if (in_valid) state_nxt = brf_pkg::S_EXEC;
      end
      brf_pkg::S_EXEC: begin
        if (!sts.is_pull || !sts.can_issue) state_nxt = brf_pkg::S_DONE;
      end
      brf_pkg::S_DONE: begin
        if (out_free) state_nxt = brf_pkg::S_IDLE;
      end
      default: state_nxt = brf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      brf_pkg::S_IDLE: begin
        cmd.load_in = in_valid;
      end
      brf_pkg::S_EXEC: begin
        cmd.exec_single = !sts.is_pull;
        cmd.issue       = sts.is_pull && sts.can_issue;
      end
      brf_pkg::S_DONE: begin
        cmd.load_out = out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/brf_dp.sv
// Datapath of the byte ring FIFO: byte store, indexes, fill count,
// big-endian accumulator and result register. Depends on brf_pkg.
module brf_dp #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  brf_pkg::cmd_t                cmd,
  output brf_pkg::sts_t                sts,
  input  logic [brf_pkg::OP_W-1:0]     op,
  input  logic [brf_pkg::BYTE_W-1:0]   data_in,
  output logic                         status,
  output logic [brf_pkg::VALUE_W-1:0]  value,
  output logic [brf_pkg::TAKEN_W-1:0]  bytes_taken,
  output logic [brf_pkg::FILL_W-1:0]   fill_count
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int FW = brf_pkg::FILL_W;
  localparam int BW = brf_pkg::BYTE_W;
  localparam int VW = brf_pkg::VALUE_W;
  localparam int TW = brf_pkg::TAKEN_W;
  localparam int OW = brf_pkg::OP_W;

  logic [BW-1:0] mem [DEPTH];

  logic [OW-1:0] op_r;
  logic [BW-1:0] data_r;
  logic [IW-1:0] wr_idx_r, rd_idx_r;
  logic [CW-1:0] cnt_r;
  logic [TW-1:0] issued_r;
  logic [VW-1:0] acc_r;
  logic [BW-1:0] rdata_r;
  logic          pend_r;
  logic          err_r;
  logic          status_r;
  logic [VW-1:0] value_r;
  logic [TW-1:0] taken_r;
  logic [FW-1:0] fill_r;

  logic [TW-1:0] want;
  logic          is_pull, full, push_wr, done_ok;
  logic [IW-1:0] wr_idx_inc, rd_idx_inc;

  assign want       = brf_pkg::want_bytes(op_r);
  assign is_pull    = (want != '0);
  assign full       = (cnt_r == CW'(DEPTH));
  assign push_wr    = cmd.exec_single && (op_r == brf_pkg::OP_PUSH) && !full;
  assign done_ok    = (issued_r == want);
  assign wr_idx_inc = (wr_idx_r == IW'(DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
  assign rd_idx_inc = (rd_idx_r == IW'(DEPTH - 1)) ? '0 : rd_idx_r + 1'b1;

  assign sts.is_pull   = is_pull;
  assign sts.can_issue = (cnt_r != '0) && !done_ok;

  always_ff @(posedge clk) begin
    if (push_wr) mem[wr_idx_r] <= data_r;
    if (cmd.issue) rdata_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
      pend_r   <= 1'b0;
    end else begin
      pend_r <= cmd.issue;
      if (cmd.exec_single && (op_r == brf_pkg::OP_CLEAR)) begin
        wr_idx_r <= '0;
        rd_idx_r <= '0;
        cnt_r    <= '0;
      end else if (push_wr) begin
        wr_idx_r <= wr_idx_inc;
        cnt_r    <= cnt_r + 1'b1;
      end else if (cmd.issue) begin
        rd_idx_r <= rd_idx_inc;
        cnt_r    <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r     <= op;
      data_r   <= data_in;
      issued_r <= '0;
      acc_r    <= '0;
      err_r    <= 1'b0;
    end else begin
      if (cmd.issue) issued_r <= issued_r + 1'b1;
      if (pend_r) acc_r <= {acc_r[VW-BW-1:0], rdata_r};
      if (cmd.exec_single) begin
        err_r <= (op_r == brf_pkg::OP_PUSH) ? full : (op_r != brf_pkg::OP_CLEAR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r <= is_pull ? !done_ok : err_r;
      value_r  <= (is_pull && done_ok) ? acc_r : '0;
      taken_r  <= issued_r;
      fill_r   <= FW'(cnt_r);
    end
  end

  assign status      = status_r;
  assign value       = value_r;
  assign bytes_taken = taken_r;
  assign fill_count  = fill_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  a_issue_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (cnt_r != '0) && is_pull)
    else $error("read issued from empty store or for a non-pull word");

  a_issue_pend: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |=> pend_r)
    else $error("issued read not marked pending");

  a_load_settled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !pend_r && !cmd.issue)
    else $error("result loaded while a byte is still in flight");

endmodule

>>> hw/rtl/byte_ring_fifo_multibyte_pull_core.sv
// Top level of the byte ring FIFO with big-endian multi-byte pulls.
// Joins brf_ctrl and brf_dp; uses brf_pkg, brf_in_if and brf_out_if.
//
// Usage: each input word carries an op (push byte, pull byte, pull 16-bit,
// pull 32-bit, clear) and a data byte used by push. Every accepted word gives
// exactly one result word with status, the pulled value assembled big-endian,
// the number of bytes removed and the fill count after the operation.
// Words are processed one at a time. Pulls remove bytes through the single
// read port of the byte store, which delivers one byte per cycle into the
// accumulator. The result appears in an output register, and the next word
// is accepted while that result still waits to be taken. When the receiver
// stalls, the block finishes the next word and then holds it until the
// output register frees, accepting nothing further meanwhile.
// Synchronous reset empties the buffer (indexes and fill count to zero) and
// drops any pending result; store contents are not cleared.
module byte_ring_fifo_multibyte_pull_core #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  brf_in_if.sink    in_s,
  brf_out_if.source out_m
);

  brf_pkg::cmd_t cmd;
  brf_pkg::sts_t sts;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_ready  (in_s.ready),
    .out_valid (out_m.valid),
    .out_ready (out_m.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .op          (in_s.op),
    .data_in     (in_s.data_in),
    .status      (out_m.status),
    .value       (out_m.value),
    .bytes_taken (out_m.bytes_taken),
    .fill_count  (out_m.fill_count)
  );

endmodule
